// ===== sv/lpp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpp_pkg - shared types and constants for landmark peak pairing
// Seed store layout, configuration block, result record and helpers.
// ----------------------------------------------------------------------------
package lpp_pkg;

   localparam int PENDING_DEPTH = 64;
   localparam int TIME_BITS     = 16;
   localparam int BIN_BITS      = 8;
   localparam int CNT_BITS      = 2;
   localparam int SLOTS         = 3;
   localparam int PTR_BITS      = $clog2(PENDING_DEPTH);
   localparam int OCC_BITS      = $clog2(PENDING_DEPTH + 1);

   localparam int CSR_IDX_BITS  = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIME_WINDOW    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BIN_HALF_WIDTH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAIRS_PER_SEED = 2'd2;

   localparam logic [7:0]          TIME_WINDOW_RST    = 8'd63;
   localparam logic [7:0]          BIN_HALF_WIDTH_RST = 8'd31;
   localparam logic [CNT_BITS-1:0] PAIRS_PER_SEED_RST = 2'd3;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic [7:0]          time_window;
      logic [7:0]          bin_half_width;
      logic [CNT_BITS-1:0] pairs_per_seed;
   } cfg_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]            stime;
      logic [BIN_BITS-1:0]             sbin;
      logic [CNT_BITS-1:0]             count;
      logic [SLOTS-1:0][BIN_BITS-1:0]  pbins;
      logic [SLOTS-1:0][7:0]           pgaps;
   } seed_type;

   typedef struct packed {
      logic [15:0]                     seed_time;
      logic [BIN_BITS-1:0]             seed_bin;
      logic [CNT_BITS-1:0]             partner_count;
      logic [SLOTS-1:0][BIN_BITS-1:0]  pbins;
      logic [SLOTS-1:0][7:0]           pgaps;
      logic                            truncated;
   } result_type;

   typedef struct packed {
      logic res_valid;
      logic item_done;
   } push_type;

   // circular store pointer advance, b never exceeds the depth
   function automatic logic [PTR_BITS-1:0] ptr_add(input logic [PTR_BITS-1:0] a,
                                                   input logic [OCC_BITS-1:0] b);
      logic [OCC_BITS:0] sum;
      sum = {{(OCC_BITS+1-PTR_BITS){1'b0}}, a} + {1'b0, b};
      if (sum >= (OCC_BITS+1)'(PENDING_DEPTH)) begin
         sum = sum - (OCC_BITS+1)'(PENDING_DEPTH);
      end
      return sum[PTR_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== sv/landmark_peak_pairing.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// landmark_peak_pairing - pairs spectral peaks with earlier seed peaks
// Top level: configuration registers, seed sequencer and result output.
// ----------------------------------------------------------------------------
// Peaks arrive on the req_ stream in nondecreasing time order; req_tuser
// selects add (0) or drain (1). Each request yields zero or more results
// on the rsp_ stream, one per closed seed that holds partners, the last one
// of a request flagged by rsp_tlast. Registers are written on the csr_
// channel, which is always ready; write only while no request is in work.
// One request at a time is handled. In an add request the match pass reads
// one seed per cycle from the seed memory and writes any updated one back
// in the next cycle; each closing step passes through a read state and an
// evaluate state. The store holds up to 64 seeds, and a drain closes every
// seed in it.
// A result is held back one step until the next result or the end of its
// request is known, then moves to the output register; results continue
// to form while the receiver stalls, up to one held and one presented.
// Reset empties the store and loads the register defaults (63, 31, 3);
// the seed memory itself is not cleared.
// ----------------------------------------------------------------------------
module landmark_peak_pairing
   import lpp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [23:0]             req_tdata,  // peak_time, peak_bin
   input  logic                    req_tuser,  // operation
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [79:0]             rsp_tdata,  // seed_time, seed_bin, partner_count,
                                               // bin_a, gap_a, bin_b, gap_b, bin_c,
                                               // gap_c, zero pad
   output logic                    rsp_tuser,  // truncated
   output logic                    rsp_tlast,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [7:0]              csr_data
);

   cfg_type    cfg_ff, cfg_in;
   push_type   push;
   result_type res;
   logic       push_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TIME_WINDOW:    cfg_in.time_window    = csr_data;
            CSR_BIN_HALF_WIDTH: cfg_in.bin_half_width = csr_data;
            CSR_PAIRS_PER_SEED: cfg_in.pairs_per_seed = csr_data[CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_window    <= TIME_WINDOW_RST;
         cfg_ff.bin_half_width <= BIN_HALF_WIDTH_RST;
         cfg_ff.pairs_per_seed <= PAIRS_PER_SEED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_time   (req_tdata[15:0]),
      .req_bin    (req_tdata[23:16]),
      .push       (push),
      .res        (res),
      .push_ready (push_ready)
   );

   lpp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .res        (res),
      .push_ready (push_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== sv/lpp_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpp_match - seed evaluation
// Tests one seed against the current peak: partner hit with slot update,
// window expiry and full status.
// ----------------------------------------------------------------------------
module lpp_match
   import lpp_pkg::*;
(
   input  seed_type             seed,
   input  logic [TIME_BITS-1:0] peak_time,
   input  logic [BIN_BITS-1:0]  peak_bin,
   input  cfg_type              cfg,
   output seed_type             upd,
   output logic                 hit,
   output logic                 expired,
   output logic                 full
);

   logic [TIME_BITS-1:0] gap;
   logic [BIN_BITS-1:0]  bin_dist;
   logic                 later;
   logic                 in_window;

   always_comb begin
      gap       = peak_time - seed.stime;
      bin_dist  = (peak_bin > seed.sbin) ? (peak_bin - seed.sbin) : (seed.sbin - peak_bin);
      later     = peak_time > seed.stime;
      in_window = gap < TIME_BITS'(cfg.time_window);
      hit       = later && in_window && (bin_dist < cfg.bin_half_width) &&
                  (seed.count < cfg.pairs_per_seed) && (seed.count < CNT_BITS'(SLOTS));
      expired   = (peak_time >= seed.stime) && !in_window;
      full      = seed.count >= cfg.pairs_per_seed;

      upd = seed;
      if (hit) begin
         upd.count = seed.count + 1'b1;
         case (seed.count)
            2'd0: begin
               upd.pbins[0] = peak_bin;
               upd.pgaps[0] = gap[7:0];
            end
            2'd1: begin
               upd.pbins[1] = peak_bin;
               upd.pgaps[1] = gap[7:0];
            end
            default: begin
               upd.pbins[2] = peak_bin;
               upd.pgaps[2] = gap[7:0];
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== sv/lpp_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpp_out - result hold and output register
// Holds the newest result until the next one or the end of the request is
// known, so the final result of a request goes out with tlast set.
// ----------------------------------------------------------------------------
module lpp_out
   import lpp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  push_type    push,
   input  result_type  res,
   output logic        push_ready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // seed_time, seed_bin, partner_count, bin_a, gap_a,
                                   // bin_b, gap_b, bin_c, gap_c, zero pad
   output logic        rsp_tuser,  // truncated
   output logic        rsp_tlast
);

   logic       hold_vld_ff, hold_vld_in;
   result_type hold_ff, hold_in;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff, out_in;
   logic       out_last_ff, out_last_in;
   logic       out_free;

   always_comb begin
      out_free    = !out_vld_ff || rsp_tready;
      push_ready  = !hold_vld_ff || out_free;
      hold_vld_in = hold_vld_ff;
      hold_in     = hold_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      if (push.res_valid && push_ready) begin
         if (hold_vld_ff) begin
            out_vld_in  = 1'b1;
            out_in      = hold_ff;
            out_last_in = 1'b0;
         end
         hold_in     = res;
         hold_vld_in = 1'b1;
      end
      if (push.item_done && push_ready) begin
         if (hold_vld_ff) begin
            out_vld_in  = 1'b1;
            out_in      = hold_ff;
            out_last_in = 1'b1;
         end
         hold_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
      end
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.truncated;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {6'd0,
                        out_ff.pgaps[2], out_ff.pbins[2],
                        out_ff.pgaps[1], out_ff.pbins[1],
                        out_ff.pgaps[0], out_ff.pbins[0],
                        out_ff.partner_count, out_ff.seed_bin, out_ff.seed_time};

endmodule
`default_nettype wire

// ===== sv/lpp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpp_core - seed store and sequencer
// Circular seed memory with a registered read. For an add, a match pass walks all
// pending seeds with a read every cycle and write-back in the next cycle, then seeds
// are closed from the head and the new peak is appended; a drain closes every seed.
// ----------------------------------------------------------------------------
module lpp_core
   import lpp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_op,
   input  logic [TIME_BITS-1:0] req_time,
   input  logic [BIN_BITS-1:0]  req_bin,
   output push_type             push,
   output result_type           res,
   input  logic                 push_ready
);

   typedef enum logic [2:0] {
      S_IDLE, S_MATCH, S_CLOSE_RD, S_CLOSE_EV, S_STORE, S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [PTR_BITS-1:0]  head_ff, head_in;
   logic [OCC_BITS-1:0]  occ_ff, occ_in;
   logic [OCC_BITS-1:0]  issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic [PTR_BITS-1:0]  pend_addr_ff, pend_addr_in;
   logic                 drain_ff, drain_in;
   logic                 trunc_ff, trunc_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [BIN_BITS-1:0]  bin_ff, bin_in;

   seed_type             seed_ram [PENDING_DEPTH];
   seed_type             q_ff;
   logic                 rd_en;
   logic [PTR_BITS-1:0]  rd_addr;
   logic                 wr_en;
   logic [PTR_BITS-1:0]  wr_addr;
   seed_type             wr_data;

   seed_type             upd;
   logic                 hit;
   logic                 expired;
   logic                 full;
   logic                 close;
   logic                 emit;

   lpp_match u_match (
      .seed      (q_ff),
      .peak_time (time_ff),
      .peak_bin  (bin_ff),
      .cfg       (cfg),
      .upd       (upd),
      .hit       (hit),
      .expired   (expired),
      .full      (full)
   );

   always_comb begin
      res.seed_time     = 16'(q_ff.stime);
      res.seed_bin      = q_ff.sbin;
      res.partner_count = q_ff.count;
      res.pbins         = q_ff.pbins;
      res.pgaps         = q_ff.pgaps;
      res.truncated     = trunc_ff;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      drain_in     = drain_ff;
      trunc_in     = trunc_ff;
      time_in      = time_ff;
      bin_in       = bin_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = upd;
      req_tready   = 1'b0;
      push         = '0;
      close        = drain_ff || trunc_ff || expired || full;
      emit         = q_ff.count != '0;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               drain_in = req_op;
               time_in  = req_time;
               bin_in   = req_bin;
               issue_in = '0;
               pend_in  = 1'b0;
               trunc_in = 1'b0;
               state_in = (req_op == OP_DRAIN) ? S_CLOSE_RD : S_MATCH;
            end
         end
         S_MATCH: begin
            // write-back of the seed read last cycle, never the one read now
            if (pend_ff && hit) begin
               wr_en = 1'b1;
            end
            if (issue_ff < occ_ff) begin
               rd_en        = 1'b1;
               rd_addr      = ptr_add(head_ff, issue_ff);
               issue_in     = issue_ff + 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = rd_addr;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_CLOSE_RD;
               end
            end
         end
         S_CLOSE_RD: begin
            if (occ_ff != '0) begin
               rd_en    = 1'b1;
               state_in = S_CLOSE_EV;
            end else begin
               state_in = drain_ff ? S_DONE : S_STORE;
            end
         end
         S_CLOSE_EV: begin
            if (close) begin
               if (!emit || push_ready) begin
                  push.res_valid = emit;
                  head_in        = ptr_add(head_ff, OCC_BITS'(1));
                  occ_in         = occ_ff - 1'b1;
                  state_in       = trunc_ff ? S_STORE : S_CLOSE_RD;
               end
            end else begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            if (occ_ff == OCC_BITS'(PENDING_DEPTH)) begin
               // store full: force out the oldest seed first
               trunc_in = 1'b1;
               state_in = S_CLOSE_RD;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = ptr_add(head_ff, occ_ff);
               wr_data       = '0;
               wr_data.stime = time_ff;
               wr_data.sbin  = bin_ff;
               occ_in        = occ_ff + 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            push.item_done = 1'b1;
            if (push_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         occ_ff   <= '0;
         issue_ff <= '0;
         pend_ff  <= 1'b0;
         drain_ff <= 1'b0;
         trunc_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
         drain_ff <= drain_in;
         trunc_ff <= trunc_in;
      end
      pend_addr_ff <= pend_addr_in;
      time_ff      <= time_in;
      bin_ff       <= bin_in;
   end

   // read data stays put between reads, so a stalled close keeps its seed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         seed_ram[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= seed_ram[rd_addr];
      end
   end

endmodule
`default_nettype wire
